[design/bfst_pkg.sv]
package bfst_pkg;

	localparam int FLOW_ENTRIES_DEFAULT = 1024;
	localparam int PROBE_LIMIT_DEFAULT = 4;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int WORD_COUNT = 17;
	localparam logic [4:0] WORD_LAST = 5'd16;

	localparam logic [31:0] HASH_MUL_A = 32'h9E3779B1;
	localparam logic [31:0] HASH_MUL_B = 32'h85EBCA77;
	localparam logic [31:0] HASH_MUL_C = 32'hC2B2AE3D;
	localparam logic [31:0] HASH_MUL_D = 32'h27D4EB2F;
	localparam logic [31:0] HASH_MUL_E = 32'h2C1B3C6D;

	// Result status codes.
	localparam logic [2:0] STATUS_UPDATED = 3'd0;
	localparam logic [2:0] STATUS_NEW = 3'd1;
	localparam logic [2:0] STATUS_IGNORED = 3'd2;
	localparam logic [2:0] STATUS_FULL = 3'd3;
	localparam logic [2:0] STATUS_READ = 3'd4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CHECK,
		ST_GAP,
		ST_SQUARE,
		ST_WRITE,
		ST_STREAM
	} state_t;

	// Request handed to the hash unit.
	typedef struct packed {
		logic rd;
		logic [31:0] addr_a;
		logic [31:0] addr_b;
		logic [39:0] ports_proto;
		logic [9:0] ridx;
	} hash_req_t;

	// One table record as held in memory.
	typedef struct packed {
		logic valid;
		logic [31:0] addr_a;
		logic [31:0] addr_b;
		logic [39:0] ports_proto;
		logic [47:0] first_seen;
		logic [47:0] last_seen;
		logic [63:0] pkt;
		logic [63:0] byt;
		logic [63:0] fwd_pkt;
		logic [63:0] bwd_pkt;
		logic [63:0] fwd_byt;
		logic [63:0] bwd_byt;
		logic [31:0] len_min_max;
		logic [63:0] len_sum;
		logic [63:0] len_sq_sum;
		logic [63:0] gap_cnt;
		logic [63:0] gap_sum;
		logic [63:0] gap_sq_sum;
	} entry_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] word_of(input entry_t e, input logic [4:0] w);
		logic [63:0] v;
		case (w)
			5'd0: v = {32'd0, e.addr_a};
			5'd1: v = {32'd0, e.addr_b};
			5'd2: v = {24'd0, e.ports_proto};
			5'd3: v = {16'd0, e.first_seen};
			5'd4: v = {16'd0, e.last_seen};
			5'd5: v = e.pkt;
			5'd6: v = e.byt;
			5'd7: v = e.fwd_pkt;
			5'd8: v = e.bwd_pkt;
			5'd9: v = e.fwd_byt;
			5'd10: v = e.bwd_byt;
			5'd11: v = {32'd0, e.len_min_max};
			5'd12: v = e.len_sum;
			5'd13: v = e.len_sq_sum;
			5'd14: v = e.gap_cnt;
			5'd15: v = e.gap_sum;
			default: v = e.gap_sq_sum;
		endcase
		return v;
	endfunction

endpackage

[design/bfst_hash.sv]
module bfst_hash import bfst_pkg::*; #(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT,
	localparam int IW = $clog2(FLOW_ENTRIES)
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input hash_req_t req,
	output logic done,
	output logic [IW-1:0] idx
);

	localparam bit IS_POW2 = ((64'd1 << IW) == 64'(FLOW_ENTRIES));
	localparam logic [IW:0] N_EXT = (IW+1)'(FLOW_ENTRIES);
	localparam logic [31:0] N32 = 32'(FLOW_ENTRIES);
	localparam int SHIFT = 32 + IW;
	localparam logic [63:0] RECIP = (64'd1 << SHIFT) / 64'(FLOW_ENTRIES);
	localparam logic [32:0] RECIP_33 = RECIP[32:0];

	logic v_s1, v_s2;
	logic [31:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic [31:0] m_s2;
	logic [31:0] x;
	logic mod_start;
	logic [31:0] mod_in;
	logic [2:0] stage_q;
	logic [31:0] val_q;
	logic [64:0] prod_q;
	logic [31:0] quot;
	logic [IW:0] rem_q;
	logic done_q;
	logic [IW-1:0] idx_q;

	// First stage: four independent key products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go && !req.rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s1 <= req.addr_a * HASH_MUL_A;
		pb_s1 <= req.addr_b * HASH_MUL_B;
		pc_s1 <= req.ports_proto[31:0] * HASH_MUL_C;
		pd_s1 <= {24'd0, req.ports_proto[39:32]} * HASH_MUL_D;
		m_s2 <= x * HASH_MUL_E;
	end

	// Second stage: fold the products, then the final mixing product.
	always_comb begin
		x = pa_s1 ^ pb_s1 ^ pc_s1 ^ pd_s1;
		x = x ^ (x >> 15);
	end

	// A read reduces its index directly; a packet reduces the mixed hash.
	assign mod_start = v_s2 || (go && req.rd);
	assign mod_in = v_s2 ? (m_s2 ^ (m_s2 >> 13)) : {22'd0, req.ridx};

	// The reciprocal product gives the quotient or one less; a final subtract fixes it.
	assign quot = 32'(prod_q >> SHIFT);

	// Remainder modulo the table size: a mask for a power of two, otherwise
	// a three-stage reciprocal multiply, subtract and correction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
			done_q <= 1'b0;
		end else begin
			stage_q <= {stage_q[1:0], mod_start && !IS_POW2};
			done_q <= (mod_start && IS_POW2) || stage_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (mod_start) begin
			val_q <= mod_in;
		end
		if (stage_q[0]) begin
			prod_q <= val_q * RECIP_33;
		end
		if (stage_q[1]) begin
			rem_q <= (IW+1)'(val_q - quot * N32);
		end
		if (mod_start && IS_POW2) begin
			idx_q <= mod_in[IW-1:0];
		end else if (stage_q[2]) begin
			idx_q <= (rem_q >= N_EXT) ? IW'(rem_q - N_EXT) : rem_q[IW-1:0];
		end
	end

	assign done = done_q;
	assign idx = idx_q;

endmodule

[design/bfst_mem.sv]
module bfst_mem import bfst_pkg::*; #(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT,
	localparam int IW = $clog2(FLOW_ENTRIES)
) (
	input logic clk,
	input logic wr_en,
	input logic [IW-1:0] wr_addr,
	input entry_t wr_data,
	input logic rd_en,
	input logic [IW-1:0] rd_addr,
	output entry_t rd_data
);

	entry_t mem [FLOW_ENTRIES];
	entry_t rd_q;

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[design/bidirectional_flow_stats_table_unit.sv]
// Packet item: hash, up to PROBE_LIMIT slot reads and checks, then gap, square and write on a
// free or matching slot; one result. A non-power-of-two FLOW_ENTRIES adds the
// reciprocal-multiply remainder. Read item: hash reduction, read and check, then 17 results
// on consecutive cycles (one if the slot is empty). One item at a time; the read-check-write
// loop sets the rate. After reset the table is swept clear, one entry a cycle, with busy high.
// Results come out on done for one cycle each; the receiver cannot stall them.
module bidirectional_flow_stats_table_unit import bfst_pkg::*; #(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEFAULT,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic command,
	input logic [31:0] src_addr,
	input logic [31:0] dst_addr,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic [7:0] protocol,
	input logic [15:0] packet_length,
	input logic [47:0] arrival_time,
	input logic [9:0] read_index,
	output logic done,
	output logic [2:0] status,
	output logic [9:0] flow_index,
	output logic forward,
	output logic entry_valid_flag,
	output logic [4:0] word_select,
	output logic [63:0] word_value,
	output logic last
);

	localparam int IW = $clog2(FLOW_ENTRIES);
	localparam int PW = $clog2(PROBE_LIMIT + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(FLOW_ENTRIES - 1);
	localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LIMIT - 1);

	state_t state_q, state_d;

	logic accept;
	logic fwd_c;
	logic proto_ok;
	hash_req_t req;
	logic hash_go, hash_done;
	logic [IW-1:0] hash_idx;

	logic mem_wr, mem_rd;
	logic [IW-1:0] mem_waddr;
	entry_t mem_wdata, rdata, new_entry;

	logic cmd_q, fwd_q;
	logic [31:0] ka_q, kb_q;
	logic [39:0] pp_q;
	logic [15:0] len_q;
	logic [47:0] now_q;
	logic [31:0] len_sq_q;
	logic [IW-1:0] slot_q, clr_q;
	logic [PW-1:0] probe_q;
	logic fresh_q;
	entry_t ent_q;
	logic [31:0] gap_q;
	logic [63:0] gap_sq_q;
	logic [4:0] word_q;
	logic key_match;

	logic done_q, fwd_out_q, evf_q, last_q;
	logic [2:0] status_q;
	logic [9:0] fidx_q;
	logic [4:0] wsel_q;
	logic [63:0] wval_q;

	assign accept = start && (state_q == ST_IDLE);
	assign proto_ok = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);

	// Canonical ordering: the lower (address, port) endpoint comes first.
	assign fwd_c = !((dst_addr < src_addr) || ((dst_addr == src_addr) && (dst_port < src_port)));

	always_comb begin
		req.rd = command;
		req.addr_a = fwd_c ? src_addr : dst_addr;
		req.addr_b = fwd_c ? dst_addr : src_addr;
		req.ports_proto = fwd_c ? {src_port, dst_port, protocol} : {dst_port, src_port, protocol};
		req.ridx = read_index;
	end

	bfst_hash #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.go(hash_go),
		.req(req),
		.done(hash_done),
		.idx(hash_idx)
	);

	bfst_mem #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_mem (
		.clk(clk),
		.wr_en(mem_wr),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en(mem_rd),
		.rd_addr(slot_q),
		.rd_data(rdata)
	);

	assign key_match = (rdata.addr_a == ka_q) && (rdata.addr_b == kb_q)
		&& (rdata.ports_proto == pp_q);

	// Updated or freshly created record.
	always_comb begin
		logic [15:0] mn, mx;
		new_entry = ent_q;
		mn = ent_q.len_min_max[31:16];
		mx = ent_q.len_min_max[15:0];
		if (len_q < mn) begin
			mn = len_q;
		end
		if (len_q > mx) begin
			mx = len_q;
		end
		if (fresh_q) begin
			new_entry.valid = 1'b1;
			new_entry.addr_a = ka_q;
			new_entry.addr_b = kb_q;
			new_entry.ports_proto = pp_q;
			new_entry.first_seen = now_q;
			new_entry.last_seen = now_q;
			new_entry.pkt = 64'd1;
			new_entry.byt = {48'd0, len_q};
			new_entry.fwd_pkt = fwd_q ? 64'd1 : 64'd0;
			new_entry.bwd_pkt = fwd_q ? 64'd0 : 64'd1;
			new_entry.fwd_byt = fwd_q ? {48'd0, len_q} : 64'd0;
			new_entry.bwd_byt = fwd_q ? 64'd0 : {48'd0, len_q};
			new_entry.len_min_max = {len_q, len_q};
			new_entry.len_sum = {48'd0, len_q};
			new_entry.len_sq_sum = {32'd0, len_sq_q};
			new_entry.gap_cnt = '0;
			new_entry.gap_sum = '0;
			new_entry.gap_sq_sum = '0;
		end else begin
			new_entry.gap_cnt = sat_add(ent_q.gap_cnt, 64'd1);
			new_entry.gap_sum = sat_add(ent_q.gap_sum, {32'd0, gap_q});
			new_entry.gap_sq_sum = sat_add(ent_q.gap_sq_sum, gap_sq_q);
			new_entry.last_seen = now_q;
			new_entry.len_min_max = {mn, mx};
			new_entry.len_sum = sat_add(ent_q.len_sum, {48'd0, len_q});
			new_entry.len_sq_sum = sat_add(ent_q.len_sq_sum, {32'd0, len_sq_q});
			new_entry.pkt = sat_add(ent_q.pkt, 64'd1);
			new_entry.byt = sat_add(ent_q.byt, {48'd0, len_q});
			if (fwd_q) begin
				new_entry.fwd_pkt = sat_add(ent_q.fwd_pkt, 64'd1);
				new_entry.fwd_byt = sat_add(ent_q.fwd_byt, {48'd0, len_q});
			end else begin
				new_entry.bwd_pkt = sat_add(ent_q.bwd_pkt, 64'd1);
				new_entry.bwd_byt = sat_add(ent_q.bwd_byt, {48'd0, len_q});
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d = state_q;
		hash_go = 1'b0;
		mem_rd = 1'b0;
		mem_wr = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = new_entry;
		case (state_q)
			ST_CLEAR: begin
				mem_wr = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && (command || proto_ok)) begin
					hash_go = 1'b1;
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_rd = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (cmd_q) begin
					state_d = rdata.valid ? ST_STREAM : ST_IDLE;
				end else if (!rdata.valid || key_match) begin
					state_d = ST_GAP;
				end else if (probe_q == LAST_PROBE) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_GAP: state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_WRITE;
			ST_WRITE: begin
				mem_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_STREAM: begin
				if (word_q == WORD_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: clearing sweep counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= (accept && !command && !proto_ok)
				|| (state_q == ST_CHECK && cmd_q && !rdata.valid)
				|| (state_q == ST_CHECK && !cmd_q && rdata.valid && !key_match
					&& probe_q == LAST_PROBE)
				|| (state_q == ST_WRITE) || (state_q == ST_STREAM);
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= command;
					fwd_q <= fwd_c;
					ka_q <= req.addr_a;
					kb_q <= req.addr_b;
					pp_q <= req.ports_proto;
					len_q <= packet_length;
					now_q <= arrival_time;
					len_sq_q <= packet_length * packet_length;
					// Ignored protocol answers at once.
					status_q <= STATUS_IGNORED;
					fidx_q <= '0;
					fwd_out_q <= 1'b0;
					evf_q <= 1'b0;
					wsel_q <= '0;
					wval_q <= '0;
					last_q <= 1'b1;
				end
			end
			ST_HASH: begin
				slot_q <= hash_idx;
				probe_q <= '0;
			end
			ST_CHECK: begin
				ent_q <= rdata;
				fresh_q <= !rdata.valid;
				word_q <= '0;
				fidx_q <= cmd_q ? 10'(32'(slot_q)) : 10'd0;
				fwd_out_q <= cmd_q ? 1'b0 : fwd_q;
				evf_q <= 1'b0;
				wsel_q <= '0;
				wval_q <= '0;
				last_q <= 1'b1;
				if (cmd_q) begin
					status_q <= STATUS_READ;
				end else begin
					status_q <= STATUS_FULL;
				end
				probe_q <= probe_q + 1'b1;
				// Step to the next probe slot only when this one holds another flow.
				if (cmd_q || !rdata.valid || key_match) begin
					slot_q <= slot_q;
				end else begin
					slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
				end
			end
			ST_GAP: begin
				if (now_q < ent_q.last_seen) begin
					gap_q <= '0;
				end else if ((now_q - ent_q.last_seen) > 48'hFFFF_FFFF) begin
					gap_q <= '1;
				end else begin
					gap_q <= 32'(now_q - ent_q.last_seen);
				end
			end
			ST_SQUARE: begin
				gap_sq_q <= {32'd0, gap_q} * {32'd0, gap_q};
			end
			ST_WRITE: begin
				status_q <= fresh_q ? STATUS_NEW : STATUS_UPDATED;
				fidx_q <= 10'(32'(slot_q));
				fwd_out_q <= fwd_q;
				evf_q <= 1'b0;
				wsel_q <= '0;
				wval_q <= '0;
				last_q <= 1'b1;
			end
			ST_STREAM: begin
				status_q <= STATUS_READ;
				fidx_q <= 10'(32'(slot_q));
				fwd_out_q <= 1'b0;
				evf_q <= 1'b1;
				wsel_q <= word_q;
				wval_q <= word_of(ent_q, word_q);
				last_q <= (word_q == WORD_LAST);
				word_q <= word_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign flow_index = fidx_q;
	assign forward = fwd_out_q;
	assign entry_valid_flag = evf_q;
	assign word_select = wsel_q;
	assign word_value = wval_q;
	assign last = last_q;

endmodule

[design/bfst_checker.sv]
module bfst_checker import bfst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic done,
	input logic [2:0] status,
	input logic entry_valid_flag,
	input logic [4:0] word_select,
	input logic [63:0] word_value,
	input logic last
);

	// Status codes stay within the defined set.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= STATUS_READ))
		else $error("undefined status code");

	// Packet results are single and carry no entry word.
	a_packet: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STATUS_READ |-> last && word_select == 5'd0 && word_value == 64'd0)
		else $error("packet result malformed");

	// An entry stream runs without gaps until its last word.
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done && word_select == $past(word_select) + 5'd1)
		else $error("entry stream broken");

	// An empty entry read ends at once.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_READ && !entry_valid_flag |-> last)
		else $error("empty read not single");

endmodule

bind bidirectional_flow_stats_table_unit bfst_checker u_bfst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.done(done),
	.status(status),
	.entry_valid_flag(entry_valid_flag),
	.word_select(word_select),
	.word_value(word_value),
	.last(last)
);
